>>> rtl/serp_pkg.sv
// Shared types, constants and round functions of the Serpent encryption engine.
package serp_pkg;

  localparam int unsigned Rounds = 32;
  localparam int unsigned RkWords = 132;
  localparam int unsigned KeyBytes = 32;
  localparam logic [31:0] GoldenFrac = 32'h9e3779b9;

  localparam logic [2:0] RegKeyWord0 = 3'd0;
  localparam logic [2:0] RegKeyWord1 = 3'd1;
  localparam logic [2:0] RegKeyWord2 = 3'd2;
  localparam logic [2:0] RegKeyWord3 = 3'd3;
  localparam logic [2:0] RegKeyLength = 3'd4;

  typedef logic [3:0][31:0] blk_t;

  typedef struct packed {
    logic busy;
    logic ready;
  } ks_status_t;

  localparam logic [15:0][3:0] SB0 = {4'd12, 4'd9, 4'd0, 4'd7, 4'd2, 4'd4, 4'd13, 4'd14,
    4'd11, 4'd5, 4'd6, 4'd10, 4'd1, 4'd15, 4'd8, 4'd3};
  localparam logic [15:0][3:0] SB1 = {4'd4, 4'd3, 4'd13, 4'd6, 4'd8, 4'd14, 4'd11, 4'd1,
    4'd10, 4'd5, 4'd0, 4'd9, 4'd7, 4'd2, 4'd12, 4'd15};
  localparam logic [15:0][3:0] SB2 = {4'd2, 4'd5, 4'd11, 4'd0, 4'd4, 4'd14, 4'd1, 4'd13,
    4'd15, 4'd10, 4'd12, 4'd3, 4'd9, 4'd7, 4'd6, 4'd8};
  localparam logic [15:0][3:0] SB3 = {4'd14, 4'd5, 4'd7, 4'd10, 4'd4, 4'd2, 4'd1, 4'd13,
    4'd3, 4'd6, 4'd9, 4'd12, 4'd8, 4'd11, 4'd15, 4'd0};
  localparam logic [15:0][3:0] SB4 = {4'd13, 4'd7, 4'd14, 4'd9, 4'd10, 4'd4, 4'd5, 4'd2,
    4'd6, 4'd11, 4'd0, 4'd12, 4'd3, 4'd8, 4'd15, 4'd1};
  localparam logic [15:0][3:0] SB5 = {4'd1, 4'd7, 4'd6, 4'd13, 4'd8, 4'd14, 4'd3, 4'd0,
    4'd12, 4'd9, 4'd10, 4'd4, 4'd11, 4'd2, 4'd5, 4'd15};
  localparam logic [15:0][3:0] SB6 = {4'd0, 4'd10, 4'd3, 4'd13, 4'd15, 4'd1, 4'd9, 4'd14,
    4'd11, 4'd6, 4'd4, 4'd8, 4'd5, 4'd12, 4'd2, 4'd7};
  localparam logic [15:0][3:0] SB7 = {4'd6, 4'd5, 4'd3, 4'd9, 4'd10, 4'd12, 4'd4, 4'd7,
    4'd11, 4'd2, 4'd8, 4'd14, 4'd0, 4'd15, 4'd13, 4'd1};

  function automatic logic [3:0] sbox_lookup(logic [2:0] s, logic [3:0] nib);
    logic [3:0] m;
    case (s)
      3'd0: m = SB0[nib];
      3'd1: m = SB1[nib];
      3'd2: m = SB2[nib];
      3'd3: m = SB3[nib];
      3'd4: m = SB4[nib];
      3'd5: m = SB5[nib];
      3'd6: m = SB6[nib];
      3'd7: m = SB7[nib];
      default: m = 4'd0;
    endcase
    return m;
  endfunction

  function automatic blk_t apply_sbox(logic [2:0] s, blk_t v);
    blk_t o;
    logic [3:0] m;
    for (int j = 0; j < 32; j++) begin
      m = sbox_lookup(s, {v[3][j], v[2][j], v[1][j], v[0][j]});
      o[0][j] = m[0];
      o[1][j] = m[1];
      o[2][j] = m[2];
      o[3][j] = m[3];
    end
    return o;
  endfunction

  function automatic logic [31:0] rotl(logic [31:0] x, int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic blk_t lin_tf(blk_t v);
    blk_t t;
    t = v;
    t[0] = rotl(t[0], 13);
    t[2] = rotl(t[2], 3);
    t[1] = t[1] ^ t[0] ^ t[2];
    t[3] = t[3] ^ t[2] ^ (t[0] << 3);
    t[1] = rotl(t[1], 1);
    t[3] = rotl(t[3], 7);
    t[0] = t[0] ^ t[1] ^ t[3];
    t[2] = t[2] ^ t[3] ^ (t[1] << 7);
    t[0] = rotl(t[0], 5);
    t[2] = rotl(t[2], 22);
    return t;
  endfunction

endpackage

>>> rtl/serp_keysched.sv
// Round-key generator: one prekey word per cycle, then an S-box pass per round key.
module serp_keysched (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        restart_i,
  input  logic [255:0]                key_i,
  input  logic [5:0]                  key_len_i,
  output logic [32:0][127:0]          rk_o,
  output serp_pkg::ks_status_t        status_o
);

  logic [7:0][31:0] win_q, win_d;
  logic [7:0]       cnt_q, cnt_d;
  logic             run_q, run_d;
  logic [3:0][31:0] grp_q, grp_d;
  logic [32:0][127:0] rk_q;
  logic [255:0]     padded;
  logic [5:0]       len;
  logic [31:0]      nw;
  logic [5:0]       rk_idx;
  logic             rk_we;

  // Bytes past the length are cleared; a short key gets a 0x01 marker at the length.
  always_comb begin
    len = (key_len_i > 6'd32) ? 6'd32 : key_len_i;
    for (int i = 0; i < 32; i++) begin
      padded[8*i +: 8] = (6'(i) < len) ? key_i[8*i +: 8] :
                         ((6'(i) == len) ? 8'h01 : 8'h00);
    end
  end

  assign nw = serp_pkg::rotl(win_q[0] ^ win_q[3] ^ win_q[5] ^ win_q[7]
                             ^ serp_pkg::GoldenFrac ^ {24'd0, cnt_q}, 11);

  always_comb begin
    win_d  = win_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    grp_d  = grp_q;
    rk_we  = 1'b0;
    rk_idx = cnt_q[7:2];
    if (restart_i) begin
      win_d = padded;
      cnt_d = 8'd0;
      run_d = 1'b1;
    end else if (run_q) begin
      win_d = {nw, win_q[7:1]};
      grp_d[cnt_q[1:0]] = nw;
      if (cnt_q[1:0] == 2'd3) begin
        rk_we = 1'b1;
      end
      cnt_d = cnt_q + 8'd1;
      if (cnt_q == 8'(serp_pkg::RkWords - 1)) begin
        run_d = 1'b0;
      end
    end
  end

  logic [3:0][31:0] full_grp;
  always_comb begin
    full_grp = grp_q;
    full_grp[3] = nw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 8'd0;
      run_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    grp_q <= grp_d;
    if (rk_we) begin
      rk_q[rk_idx] <= serp_pkg::apply_sbox(3'(6'd35 - rk_idx), full_grp);
    end
  end

  assign rk_o = rk_q;
  assign status_o.busy  = run_q;
  assign status_o.ready = !run_q;

endmodule

>>> rtl/serpent_block_encrypt.sv
// Top level of the pipelined Serpent block encryption engine for 128-bit blocks.
//
// Usage: raise start_i for one cycle with a plaintext word on block_low_i and
// block_high_i; it is taken when busy_o is low. One word may enter every clock
// cycle while busy_o is low. The ciphertext appears on cipher_low_o and
// cipher_high_o, marked by done_o for one cycle, after passing an input
// register, then one register stage per round, the last also adding the
// final key. The receiver cannot stall.
//
// The key is written through cfg_we_i, cfg_addr_i and cfg_data_i. Each write
// to addresses 0 to 4, and reset, restarts the round-key generator, which
// produces one prekey word per cycle and holds busy_o high after the last
// write while it restarts and produces the 132 prekey words. After reset the
// keys are those of the all-zero 256-bit key. Words accepted earlier and still
// in the pipeline are expected to have left before a key write.
module serpent_block_encrypt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [63:0] block_low_i,
  input  logic [63:0] block_high_i,
  output logic        done_o,
  output logic [63:0] cipher_low_o,
  output logic [63:0] cipher_high_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [63:0] cfg_data_i
);

  localparam int unsigned Rounds = serp_pkg::Rounds;

  logic [3:0][63:0] key_q;
  logic [5:0]       klen_q;
  logic             restart_q;
  logic [32:0][127:0] rk;
  serp_pkg::ks_status_t ks_st;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q     <= '0;
      klen_q    <= 6'd32;
      restart_q <= 1'b1;
    end else begin
      restart_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          serp_pkg::RegKeyWord0: begin key_q[0] <= cfg_data_i; restart_q <= 1'b1; end
          serp_pkg::RegKeyWord1: begin key_q[1] <= cfg_data_i; restart_q <= 1'b1; end
          serp_pkg::RegKeyWord2: begin key_q[2] <= cfg_data_i; restart_q <= 1'b1; end
          serp_pkg::RegKeyWord3: begin key_q[3] <= cfg_data_i; restart_q <= 1'b1; end
          serp_pkg::RegKeyLength: begin
            klen_q    <= cfg_data_i[5:0];
            restart_q <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  serp_keysched u_ks (
    .clk_i,
    .rst_ni,
    .restart_i (restart_q),
    .key_i     (key_q),
    .key_len_i (klen_q),
    .rk_o      (rk),
    .status_o  (ks_st)
  );

  assign busy_o = ks_st.busy || restart_q;

  // One round per stage.
  serp_pkg::blk_t   st_q [Rounds+1];
  logic [Rounds:0]  vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Rounds-1:0], start_i && !busy_o};
    end
  end

  always_ff @(posedge clk_i) begin
    st_q[0] <= {block_high_i, block_low_i};
    for (int r = 0; r < Rounds; r++) begin
      if (r < Rounds - 1) begin
        st_q[r+1] <= serp_pkg::lin_tf(serp_pkg::apply_sbox(3'(r), st_q[r] ^ rk[r]));
      end else begin
        st_q[r+1] <= serp_pkg::apply_sbox(3'(r), st_q[r] ^ rk[r]) ^ rk[Rounds];
      end
    end
  end

  assign done_o        = vld_q[Rounds];
  assign cipher_low_o  = {st_q[Rounds][1], st_q[Rounds][0]};
  assign cipher_high_o = {st_q[Rounds][3], st_q[Rounds][2]};

endmodule

>>> rtl/serp_checker.sv
// Port-level checker for the Serpent encryption engine, bound to the top level.
module serp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       done_o,
  input logic       cfg_we_i,
  input logic [2:0] cfg_addr_i
);

  // Every result follows an accepted word by the pipeline latency.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 33))
    else $error("result without an accepted word");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##33 done_o)
    else $error("accepted word produced no result");

  // A write to a key register makes the engine busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_we_i && cfg_addr_i <= serp_pkg::RegKeyLength) |=> busy_o)
    else $error("key write did not stall intake");

endmodule

bind serpent_block_encrypt serp_checker u_chk (
  .clk_i, .rst_ni, .start_i, .busy_o, .done_o, .cfg_we_i, .cfg_addr_i
);
